// ----- hw/rtl/hqp_pkg.sv -----
// Shared constants and types for the quadratic-probe key table.
package hqp_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    localparam int KEY_IN_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
    } t_agen_ctl;

endpackage

// ----- hw/rtl/hqp_keymem.sv -----
// Key store memory with one write port and one registered read port.
module hqp_keymem
    import hqp_pkg::*;
#(
    parameter int DEPTH = TABLE_SLOTS_DEF,
    parameter int WIDTH = KEY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/hqp_agen.sv -----
// Probe address generator: byte-wise key remainder by reciprocal multiplication and modular probe stepping.
module hqp_agen
    import hqp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_agen_ctl                      i_ctl,
    input  logic [KEY_BITS-1:0]            i_key,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_pos,
    output logic                           o_busy
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int DIG_W   = 8;
    localparam int NDIG    = (KEY_BITS + DIG_W - 1) / DIG_W;
    localparam int KEY_PAD = NDIG * DIG_W;
    localparam int X_W     = SLOT_W + DIG_W;
    localparam int CNT_W   = $clog2(NDIG + 1);
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [SLOT_W:0]   N_W   = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [X_W-1:0]    N_X   = X_W'(TABLE_SLOTS);
    localparam logic [X_W-1:0]    RECIP = X_W'((1 << X_W) / TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] INC0  = SLOT_W'(1 % TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] ODD0  = SLOT_W'(3 % TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] TWO   = SLOT_W'(2 % TABLE_SLOTS);

    logic [SLOT_W-1:0]  r_pos;
    logic [SLOT_W-1:0]  r_inc;
    logic [SLOT_W-1:0]  r_odd;
    logic [KEY_PAD-1:0] r_key_sh;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_phase;
    logic [DIG_W-1:0]   r_q;
    logic               r_busy;

    logic [X_W-1:0]     w_x;
    logic [2*X_W-1:0]   w_prod;
    logic [X_W-1:0]     w_qn;
    logic [X_W-1:0]     w_rem;

    function automatic logic [SLOT_W-1:0] f_reduce(input logic [SLOT_W:0] s);
        logic [SLOT_W:0] d;
        d = s - N_W;
        return (s >= N_W) ? d[SLOT_W-1:0] : s[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] f_modadd(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        return f_reduce({1'b0, a} + {1'b0, b});
    endfunction

    // The estimated quotient is at most one short, so one compare and subtract finishes the byte.
    assign w_x    = {r_pos, r_key_sh[KEY_PAD-1 -: DIG_W]};
    assign w_prod = {{X_W{1'b0}}, w_x} * {{X_W{1'b0}}, RECIP};
    assign w_qn   = {{SLOT_W{1'b0}}, r_q} * N_X;
    assign w_rem  = w_x - w_qn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else if (i_ctl.load) begin
            r_inc <= INC0;
            r_odd <= ODD0;
            if (IS_POW2) begin
                r_pos  <= SLOT_W'(i_key);
                r_busy <= 1'b0;
            end else begin
                r_pos    <= '0;
                r_key_sh <= KEY_PAD'(i_key);
                r_cnt    <= CNT_W'(NDIG);
                r_phase  <= 1'b0;
                r_busy   <= 1'b1;
            end
        end else if (r_busy) begin
            if (!r_phase) begin
                r_q     <= w_prod[X_W +: DIG_W];
                r_phase <= 1'b1;
            end else begin
                r_pos    <= f_reduce(w_rem[SLOT_W:0]);
                r_key_sh <= r_key_sh << DIG_W;
                r_cnt    <= r_cnt - 1'b1;
                r_phase  <= 1'b0;
                r_busy   <= (r_cnt != CNT_W'(1));
            end
        end else if (i_ctl.step) begin
            r_pos <= f_modadd(r_pos, r_inc);
            r_inc <= f_modadd(r_inc, r_odd);
            r_odd <= f_modadd(r_odd, TWO);
        end
    end

    assign o_pos  = r_pos;
    assign o_busy = r_busy;

endmodule

// ----- hw/rtl/hash_table_quadratic_probe.sv -----
// Top level of the quadratic-probe key table: sequencer, key store and address generator.
//
//  Channel  Valid        Stall         Payload
//  input    i_in_valid   o_in_stall    i_func, i_key
//  output   o_out_valid  i_out_stall   o_status, o_slot
//
// After reset the key store is cleared one slot per cycle, with input stalled.
// After acceptance an operation computes the key remainder (byte-wise unless TABLE_SLOTS is a
// power of two), then probes up to TABLE_SLOTS slots at one key store read per cycle, then
// ends in the final state. A zero key goes straight to the final state, which repeats while an
// earlier result still waits unread in the output register.
// One transaction is in work at a time; a finished result waits while the next one is accepted.
module hash_table_quadratic_probe
    import hqp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [KEY_IN_W-1:0]   i_key,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_OUT_W-1:0] o_slot
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W:0]   N_CNT  = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W:0]   N_LAST = (SLOT_W + 1)'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [SLOT_W-1:0]     r_clr_idx;
    logic                  r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [SLOT_W:0]       r_issued;
    logic                  r_chk_vld;
    logic                  r_chk_last;
    logic [SLOT_W-1:0]     r_pos_d;
    logic [STATUS_W-1:0]   r_res_status;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    logic                  r_out_vld;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    logic                  w_accept;
    logic [KEY_BITS-1:0]   w_key;
    t_agen_ctl             w_agen_ctl;
    logic [SLOT_W-1:0]     w_pos;
    logic                  w_rem_busy;
    logic [KEY_BITS-1:0]   w_rd_data;
    logic                  w_issue;
    logic                  w_chk;
    logic                  w_hit_empty;
    logic                  w_hit_key;
    logic                  w_ins_new;
    logic                  w_rem_hit;
    logic                  w_mem_we;
    logic [SLOT_W-1:0]     w_mem_waddr;
    logic [KEY_BITS-1:0]   w_mem_wdata;
    logic                  w_out_free;

    assign w_key      = KEY_BITS'(i_key);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_issue    = (r_state == S_PROBE) && (r_issued != N_CNT);
    assign w_chk      = (r_state == S_PROBE) && r_chk_vld;
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        w_agen_ctl.load = w_accept && (w_key != '0);
        w_agen_ctl.step = w_issue;
        w_hit_empty     = (r_func == FUNC_INSERT) && (w_rd_data == '0);
        w_hit_key       = (w_rd_data == r_key);
        w_ins_new       = w_chk && w_hit_empty;
        w_rem_hit       = w_chk && (r_func == FUNC_REMOVE) && w_hit_key;
        w_mem_we        = (r_state == S_CLEAR) || w_ins_new || w_rem_hit;
        w_mem_waddr     = (r_state == S_CLEAR) ? r_clr_idx : r_pos_d;
        w_mem_wdata     = w_ins_new ? r_key : '0;
    end

    hqp_agen #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_agen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_agen_ctl),
        .i_key   (w_key),
        .o_pos   (w_pos),
        .o_busy  (w_rem_busy)
    );

    hqp_keymem #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (KEY_BITS)
    ) u_keymem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_pos),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_issued   <= '0;
            r_chk_vld  <= 1'b0;
            r_chk_last <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= i_func;
                        r_key  <= w_key;
                        if (w_key == '0) begin
                            r_res_status <= ST_ZERO;
                            r_res_slot   <= '0;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (!w_rem_busy) begin
                        r_issued   <= '0;
                        r_chk_vld  <= 1'b0;
                        r_chk_last <= 1'b0;
                        r_state    <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_chk_vld <= w_issue;
                    r_pos_d   <= w_pos;
                    if (w_issue) begin
                        r_issued   <= r_issued + 1'b1;
                        r_chk_last <= (r_issued == N_LAST);
                    end
                    if (w_ins_new || w_rem_hit) begin
                        r_res_status <= ST_OK;
                        r_res_slot   <= SLOT_OUT_W'(r_pos_d);
                        r_state      <= S_FIN;
                    end else if (w_chk && w_hit_key) begin
                        r_res_status <= ST_DUP;
                        r_res_slot   <= '0;
                        r_state      <= S_FIN;
                    end else if (w_chk && r_chk_last) begin
                        r_res_status <= ST_MISS;
                        r_res_slot   <= '0;
                        r_state      <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_status <= r_res_status;
                        r_out_slot   <= r_res_slot;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_PROBE))
        else $error("key store written outside clear or probe");

    a_write_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && r_state == S_PROBE) |-> r_chk_vld)
        else $error("key store written without a checked probe");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued <= N_CNT)
        else $error("probe count beyond slot count");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MOD || r_state == S_FIN))
        else $error("accepted transaction not started");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_slot == '0))
        else $error("nonzero slot on failed transaction");

endmodule
